// File: rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = ADDR_W + 1;

   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   localparam cnt_type LIMIT_RESET = cnt_type'(CAPACITY);
   localparam cnt_type CAP_COUNT   = cnt_type'(CAPACITY);

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_LOAD,
      S_DN_FETCH,
      S_DN_RD,
      S_DN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      addr_type rd_a_addr;
      addr_type rd_b_addr;
      logic     wr_en;
      addr_type wr_addr;
      key_type  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic    ok;
      key_type removed_value;
      cnt_type count;
   } result_type;

endpackage

// File: rtl/mhpq_req_if.sv
// Request channel: operation code and key.
interface mhpq_req_if;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   mhpq_pkg::key_type     value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: rtl/mhpq_rsp_if.sv
// Response channel: status, removed key and entry count.
interface mhpq_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  ok;
   mhpq_pkg::key_type     removed_value;
   mhpq_pkg::cnt_type     count;

   modport source (output valid, output ok, output removed_value, output count, input ready);
   modport sink   (input valid, input ok, input removed_value, input count, output ready);
endinterface

// File: rtl/max_heap_priority_queue_core.sv
// Max-heap priority queue: top level with limit register and response word register.
//
// Requests arrive on req_chan: mode 0 inserts value, mode 1 removes the maximum.
// Every request gives exactly one response word on rsp_chan carrying ok, the
// removed key (zero unless a remove succeeded) and the entry count afterwards.
// csr_wr_en/csr_wr_data write the capacity limit (reset 64, saturated at 64);
// an insert fails once the count reaches the limit, a remove fails when empty.
// A failed request goes straight to the final state; an insert climbs a level
// at a time until a parent stops it or it reaches the root; a remove first reads
// the root and the last entry, finishes there if that empties the heap, else
// sinks a level at a time until a child stops it or it reaches a leaf. Each
// level is one registered read of the key store then one compare and write.
// One request is in flight at a time; req_chan.ready is high only while idle.
// The response sits in an output register, so a new request is taken while the
// previous word waits; if that word is still held when the next finishes, the
// sequencer waits in its final state until rsp_chan.ready frees the register.
// Reset (synchronous) empties the heap and restores the limit; key store
// contents are not cleared and need no clearing pass.
module max_heap_priority_queue_core (
   input  logic              clock,
   input  logic              reset,
   mhpq_req_if.sink          req_chan,
   mhpq_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  mhpq_pkg::cnt_type csr_wr_data
);
   import mhpq_pkg::*;

   cnt_type     limit_ff;
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   logic        idle;
   logic        slot_free;
   logic        res_valid;
   result_type  res;
   mem_req_type mem_req;
   key_type     rd_a_data;
   key_type     rd_b_data;

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.ok            = rsp_ff.ok;
   assign rsp_chan.removed_value = rsp_ff.removed_value;
   assign rsp_chan.count         = rsp_ff.count;

   mhpq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_chan.valid),
      .mode      (req_chan.mode),
      .value     (req_chan.value),
      .limit     (limit_ff),
      .slot_free (slot_free),
      .idle      (idle),
      .res_valid (res_valid),
      .res       (res),
      .mem_req   (mem_req),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   mhpq_store u_store (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

endmodule

// File: rtl/mhpq_store.sv
// Heap key store: one write port, two registered read ports.
module mhpq_store (
   input  logic                  clock,
   input  mhpq_pkg::mem_req_type mem_req,
   output mhpq_pkg::key_type     rd_a_data,
   output mhpq_pkg::key_type     rd_b_data
);
   import mhpq_pkg::*;

   key_type heap_store_ff [CAPACITY];
   key_type rd_a_ff;
   key_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         heap_store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_a_ff <= heap_store_ff[mem_req.rd_a_addr];
      rd_b_ff <= heap_store_ff[mem_req.rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// File: rtl/mhpq_seq.sv
// Sift sequencer: walks the heap one level at a time.
module mhpq_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  mode,
   input  mhpq_pkg::key_type     value,
   input  mhpq_pkg::cnt_type     limit,
   input  logic                  slot_free,
   output logic                  idle,
   output logic                  res_valid,
   output mhpq_pkg::result_type  res,
   output mhpq_pkg::mem_req_type mem_req,
   input  mhpq_pkg::key_type     rd_a_data,
   input  mhpq_pkg::key_type     rd_b_data
);
   import mhpq_pkg::*;

   state_type state_ff, state_in;
   addr_type  pos_ff, pos_in;
   key_type   key_ff, key_in;
   cnt_type   count_ff, count_in;
   logic      ok_ff, ok_in;
   key_type   removed_ff, removed_in;

   cnt_type        eff_limit;
   addr_type       parent;
   cnt_type        left;
   logic [CNT_W:0] right;
   logic           right_valid;
   logic           pick_right;
   key_type        big_key;
   addr_type       big_addr;

   assign eff_limit   = (limit > CAP_COUNT) ? CAP_COUNT : limit;
   assign parent      = addr_type'((pos_ff - addr_type'(1)) >> 1);
   assign left        = {pos_ff, 1'b1};
   assign right       = {1'b0, pos_ff, 1'b0} + (CNT_W + 1)'(2);
   assign right_valid = right < {1'b0, count_ff};
   // right child wins only when present and strictly larger
   assign pick_right  = right_valid && (rd_a_data < rd_b_data);
   assign big_key     = pick_right ? rd_b_data : rd_a_data;
   assign big_addr    = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      ok_ff      <= ok_in;
      removed_ff <= removed_in;
   end

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      ok_in      = ok_ff;
      removed_in = removed_ff;
      mem_req    = '{rd_a_addr: parent, rd_b_addr: parent, wr_en: 1'b0,
                     wr_addr: pos_ff, wr_data: key_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ok_in      = 1'b0;
               removed_in = '0;
               state_in   = S_DONE;
               if (mode == MODE_INSERT) begin
                  if (count_ff < eff_limit) begin
                     ok_in    = 1'b1;
                     pos_in   = count_ff[ADDR_W-1:0];
                     key_in   = value;
                     count_in = count_ff + cnt_type'(1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (count_ff != '0) begin
                     ok_in    = 1'b1;
                     count_in = count_ff - cnt_type'(1);
                     state_in = S_DN_LOAD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               mem_req.wr_en = 1'b1;
               state_in      = S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_req.wr_en = 1'b1;
            if (key_ff > rd_a_data) begin
               // parent moves down, key keeps climbing
               mem_req.wr_data = rd_a_data;
               pos_in          = parent;
               state_in        = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN_LOAD: begin
            mem_req.rd_a_addr = '0;
            mem_req.rd_b_addr = count_ff[ADDR_W-1:0];
            state_in          = S_DN_FETCH;
         end
         S_DN_FETCH: begin
            removed_in = rd_a_data;
            key_in     = rd_b_data;
            pos_in     = '0;
            state_in   = (count_ff == '0) ? S_DONE : S_DN_RD;
         end
         S_DN_RD: begin
            mem_req.rd_a_addr = left[ADDR_W-1:0];
            mem_req.rd_b_addr = right[ADDR_W-1:0];
            if (left < count_ff) begin
               state_in = S_DN_CMP;
            end else begin
               mem_req.wr_en = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DN_CMP: begin
            mem_req.wr_en = 1'b1;
            if (key_ff >= big_key) begin
               state_in = S_DONE;
            end else begin
               // larger child moves up, key sinks
               mem_req.wr_data = big_key;
               pos_in          = big_addr;
               state_in        = S_DN_RD;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE) && slot_free;
   assign res       = '{ok: ok_ff, removed_value: removed_ff, count: count_ff};

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the max-heap priority queue core.
module testbench;
   import mhpq_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int REPORT_MAX  = 10;
   localparam int HOLD_CYCLES = 200;

   typedef struct {
      logic    mode;
      key_type value;
   } request_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_wr_en;
   cnt_type csr_wr_data;

   mhpq_req_if req_chan();
   mhpq_rsp_if rsp_chan();

   max_heap_priority_queue_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // heap predictor state
   key_type heap_keys [CAPACITY];
   int      heap_count = 0;
   int      heap_limit = int'(LIMIT_RESET);

   request_type request_queue [$];
   result_type  due_results [$];

   bit quiet = 1'b0;      // no idling on either side
   int hold_asked = 0;
   int hold_taken = 0;
   int cycle_count = 0;

   int mismatches = 0;
   int words_seen = 0;
   int inserts_ok = 0;
   int removes_ok = 0;
   int refused = 0;
   int peak_count = 0;
   int limit_writes = 0;

   function automatic void swap_keys(int a, int b);
      key_type t;
      t = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = t;
   endfunction

   function automatic result_type heap_apply(logic mode, key_type key);
      result_type r;
      int lim;
      int pos;
      int up;
      int big;
      r = '0;
      lim = (heap_limit > CAPACITY) ? CAPACITY : heap_limit;
      if (mode == MODE_INSERT) begin
         if (heap_count < lim) begin
            pos = heap_count;
            heap_keys[pos] = key;
            heap_count++;
            while (pos != 0) begin
               up = (pos - 1) / 2;
               if (heap_keys[pos] <= heap_keys[up]) break;
               swap_keys(pos, up);
               pos = up;
            end
            r.ok = 1'b1;
         end
      end else if (heap_count != 0) begin
         heap_count--;
         swap_keys(0, heap_count);
         pos = 0;
         while (2 * pos + 1 < heap_count) begin
            big = 2 * pos + 1;
            if (big + 1 < heap_count && heap_keys[big] < heap_keys[big + 1]) big = big + 1;
            if (heap_keys[pos] >= heap_keys[big]) break;
            swap_keys(pos, big);
            pos = big;
         end
         r.removed_value = heap_keys[heap_count];
         r.ok = 1'b1;
      end
      r.count = cnt_type'(heap_count);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin : req_driver
      request_type item;
      int gap_left;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left != 0) begin
            req_chan.valid <= 1'b0;
            gap_left--;
         end else if (request_queue.size() != 0) begin
            item = request_queue.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.mode  <= item.mode;
            req_chan.value <= item.value;
            gap_left = quiet ? 0 : $urandom_range(0, 3);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // predict on every accepted request word
   always @(posedge clock) begin : heap_predict
      result_type r;
      if (!reset && req_chan.valid && req_chan.ready) begin
         r = heap_apply(req_chan.mode, req_chan.value);
         due_results.push_back(r);
         if (!r.ok) refused++;
         else if (req_chan.mode == MODE_INSERT) inserts_ok++;
         else removes_ok++;
         if (heap_count > peak_count) peak_count = heap_count;
      end
   end

   // response receiver: per-word waits plus the occasional long hold-off
   always @(posedge clock) begin : rsp_receiver
      int wait_left;
      int hold_left;
      int n;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         wait_left = 0;
         hold_left = 0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else if (hold_taken != hold_asked) begin
         rsp_chan.ready <= 1'b0;
         hold_left = HOLD_CYCLES;
         hold_taken++;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         n = quiet ? 0 : $urandom_range(0, 3);
         rsp_chan.ready <= (n == 0);
         wait_left = (n == 0) ? 0 : n - 1;
      end else if (wait_left != 0) begin
         rsp_chan.ready <= 1'b0;
         wait_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         words_seen++;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected word: ok=%0b removed=%h count=%0d",
                        rsp_chan.ok, rsp_chan.removed_value, rsp_chan.count);
         end else begin
            want = due_results.pop_front();
            if (rsp_chan.ok !== want.ok || rsp_chan.removed_value !== want.removed_value ||
                rsp_chan.count !== want.count) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("mismatch on word %0d: expected ok=%0b removed=%h count=%0d, got ok=%0b removed=%h count=%0d",
                           words_seen, want.ok, want.removed_value, want.count,
                           rsp_chan.ok, rsp_chan.removed_value, rsp_chan.count);
            end
         end
      end
   end

   task automatic push_req(logic mode, key_type value);
      request_type item;
      item.mode  = mode;
      item.value = value;
      request_queue.push_back(item);
   endtask

   task automatic push_random(int n, int insert_pct);
      key_type v;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0:       v = '0;
            1:       v = '1;
            2, 3:    v = key_type'($urandom_range(0, 7));   // plenty of equal keys
            default: v = key_type'($urandom());
         endcase
         push_req(($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE, v);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_queue.size() != 0 || req_chan.valid || due_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(int lim);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cnt_type'(lim);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      heap_limit = lim & 8'h7F;
      limit_writes++;
   endtask

   task automatic run_phase(int lim, int n, int insert_pct, bit no_idle, bit hold);
      wait_drained();
      write_limit(lim);
      quiet = no_idle;
      if (hold) hold_asked++;
      push_random(n, insert_pct);
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      req_chan.valid = 1'b0;
      req_chan.mode  = MODE_INSERT;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset limit: remove from empty, extreme and tied keys, drain past empty
      push_req(MODE_REMOVE, 32'h1234_5678);
      push_req(MODE_INSERT, 32'h0000_0000);
      push_req(MODE_INSERT, 32'hFFFF_FFFF);
      push_req(MODE_INSERT, 32'h8000_0000);
      push_req(MODE_INSERT, 32'h0000_0001);
      push_req(MODE_INSERT, 32'hFFFF_FFFF);
      push_req(MODE_INSERT, 32'h7FFF_FFFF);
      repeat (3) push_req(MODE_REMOVE, 32'hFFFF_FFFF);
      push_req(MODE_INSERT, 32'h0000_0000);
      repeat (5) push_req(MODE_REMOVE, 32'h0);

      // zero limit refuses every insert
      wait_drained();
      write_limit(0);
      push_req(MODE_INSERT, 32'hFFFF_FFFF);
      push_req(MODE_REMOVE, 32'h0);

      // small limit: last insert is refused
      wait_drained();
      write_limit(3);
      push_req(MODE_INSERT, 32'd10);
      push_req(MODE_INSERT, 32'd20);
      push_req(MODE_INSERT, 32'd30);
      push_req(MODE_INSERT, 32'd40);

      // limit dropped below the count: inserts refused while removes drain
      wait_drained();
      write_limit(1);
      push_req(MODE_INSERT, 32'd5);
      push_req(MODE_REMOVE, 32'h0);
      push_req(MODE_INSERT, 32'd6);
      push_req(MODE_REMOVE, 32'h0);
      push_req(MODE_REMOVE, 32'h0);
      push_req(MODE_INSERT, 32'd7);
      push_req(MODE_INSERT, 32'd8);

      // random phases: limit, words, insert percentage, no idling, long hold-off
      run_phase(127, 80, 80, 1'b0, 1'b0);   // saturated limit
      run_phase(64,  60, 35, 1'b0, 1'b0);
      run_phase(1,   40, 50, 1'b0, 1'b0);
      run_phase(2,   40, 60, 1'b0, 1'b0);
      run_phase(17,  60, 65, 1'b1, 1'b0);
      run_phase(64,  60, 85, 1'b1, 1'b1);   // receiver holds off, input backs up
      run_phase(0,   20, 50, 1'b0, 1'b0);
      run_phase(100, 90, 55, 1'b0, 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);

      $display("%0d words checked: %0d inserts and %0d removes taken, %0d refused",
               words_seen, inserts_ok, removes_ok, refused);
      $display("peak occupancy %0d, %0d limit writes, %0d mismatches",
               peak_count, limit_writes, mismatches);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: max_heap_priority_queue_core.f
rtl/mhpq_pkg.sv
rtl/mhpq_req_if.sv
rtl/mhpq_rsp_if.sv
rtl/mhpq_store.sv
rtl/mhpq_seq.sv
rtl/max_heap_priority_queue_core.sv
verif/testbench.sv
